// ===== design/pc_pkg.sv =====
// Shared constants, widths and request types for the Pearson correlation block.
package pc_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int SAMPLE_BITS = 16;
  localparam int FIELD_W     = 16;

  localparam int LOG_N     = $clog2(MAX_SAMPLES);
  localparam int CNT_W     = LOG_N + 1;
  localparam int SUM_W     = SAMPLE_BITS + LOG_N;
  localparam int SQ_W      = 2 * SAMPLE_BITS + LOG_N - 1;
  localparam int XY_W      = 2 * SAMPLE_BITS + LOG_N;
  localparam int V_W       = CNT_W + SQ_W;
  localparam int NUM_W     = V_W + 2;
  localparam int RAD_W     = 2 * V_W;
  localparam int FRAC_BITS = 15;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int STEP_W    = $clog2(V_W + 1);

  localparam logic signed [Q_W-1:0] CORR_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] CORR_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef struct packed {
    logic signed [FIELD_W-1:0] x_sample;
    logic signed [FIELD_W-1:0] y_sample;
    logic                      last;
  } sample_t;

  typedef struct packed {
    logic signed [Q_W-1:0] correlation;
    logic                  degenerate;
  } result_t;

endpackage

// ===== design/pearson_correlation.sv =====
// Pearson correlation top level: accumulators, shift-add multiplier, square root and divider.
// A pair without the last mark is accepted while the input is not stalled; pairs may follow back to back.
// A last pair stalls the input while the result is built: seven shift-add products
// (one multiplier bit per cycle), a 52-step square root and, unless the result is
// degenerate or saturates, a 15-step fraction divide before the result request.
// Synchronous active-high reset clears the sums, the count, the sequencer and result valid.
module pearson_correlation (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  pc_pkg::sample_t  sample,
  output logic             result_valid,
  input  logic             result_stall,
  output pc_pkg::result_t  result
);
  import pc_pkg::*;

  localparam logic [2:0] ST_ACC      = 3'd0;
  localparam logic [2:0] ST_LOAD     = 3'd1;
  localparam logic [2:0] ST_MUL      = 3'd2;
  localparam logic [2:0] ST_STORE    = 3'd3;
  localparam logic [2:0] ST_SQRT     = 3'd4;
  localparam logic [2:0] ST_DIV_INIT = 3'd5;
  localparam logic [2:0] ST_DIV      = 3'd6;
  localparam logic [2:0] ST_OUT      = 3'd7;

  localparam logic [2:0] OP_NSXX = 3'd0;
  localparam logic [2:0] OP_SXSX = 3'd1;
  localparam logic [2:0] OP_NSYY = 3'd2;
  localparam logic [2:0] OP_SYSY = 3'd3;
  localparam logic [2:0] OP_NSXY = 3'd4;
  localparam logic [2:0] OP_SXSY = 3'd5;
  localparam logic [2:0] OP_VXVY = 3'd6;

  logic [2:0]              state;
  logic [2:0]              op;
  logic [CNT_W-1:0]        pair_count;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic [SQ_W-1:0]         sum_xx;
  logic [SQ_W-1:0]         sum_yy;
  logic signed [XY_W-1:0]  sum_xy;

  logic [RAD_W-1:0]        acc;
  logic [RAD_W-1:0]        mcand;
  logic [V_W-1:0]          mplier;
  logic                    prod_neg;
  logic [V_W-1:0]          vx;
  logic [V_W-1:0]          vy;
  logic signed [NUM_W-1:0] num;
  logic [V_W-1:0]          root;
  logic [V_W:0]            srem;
  logic [STEP_W-1:0]       step;
  logic [FRAC_BITS-1:0]    frac;
  result_t                 res_hold;

  logic signed [SAMPLE_BITS-1:0]   xs, ys;
  logic signed [2*SAMPLE_BITS-1:0] pxx, pyy, pxy;
  logic                            accept;
  logic [SUM_W-1:0]                abs_x, abs_y;
  logic [XY_W-1:0]                 abs_xy;
  logic [RAD_W-1:0]                ld_a;
  logic [V_W-1:0]                  ld_b;
  logic                            ld_neg;
  logic [V_W-1:0]                  prod_v;
  logic signed [NUM_W-1:0]         sp;
  logic [V_W+2:0]                  sq_cur, sq_trial;
  logic                            sq_ge;
  logic                            neg;
  logic [NUM_W-1:0]                mag;
  logic [V_W:0]                    div_r2;
  logic                            div_ge;
  logic [FRAC_BITS-1:0]            frac_next;
  logic signed [Q_W-1:0]           corr_next;

  assign sample_stall = (state != ST_ACC);
  assign accept       = sample_valid && !sample_stall;

  assign xs  = sample.x_sample[SAMPLE_BITS-1:0];
  assign ys  = sample.y_sample[SAMPLE_BITS-1:0];
  assign pxx = xs * xs;
  assign pyy = ys * ys;
  assign pxy = xs * ys;

  assign abs_x  = sum_x[SUM_W-1]  ? unsigned'(-sum_x)  : unsigned'(sum_x);
  assign abs_y  = sum_y[SUM_W-1]  ? unsigned'(-sum_y)  : unsigned'(sum_y);
  assign abs_xy = sum_xy[XY_W-1]  ? unsigned'(-sum_xy) : unsigned'(sum_xy);

  always_comb begin
    ld_a   = '0;
    ld_b   = '0;
    ld_neg = 1'b0;
    unique case (op)
      OP_NSXX: begin
        ld_a = RAD_W'(sum_xx);
        ld_b = V_W'(pair_count);
      end
      OP_SXSX: begin
        ld_a = RAD_W'(abs_x);
        ld_b = V_W'(abs_x);
      end
      OP_NSYY: begin
        ld_a = RAD_W'(sum_yy);
        ld_b = V_W'(pair_count);
      end
      OP_SYSY: begin
        ld_a = RAD_W'(abs_y);
        ld_b = V_W'(abs_y);
      end
      OP_NSXY: begin
        ld_a   = RAD_W'(abs_xy);
        ld_b   = V_W'(pair_count);
        ld_neg = sum_xy[XY_W-1];
      end
      OP_SXSY: begin
        ld_a   = RAD_W'(abs_x);
        ld_b   = V_W'(abs_y);
        ld_neg = sum_x[SUM_W-1] ^ sum_y[SUM_W-1];
      end
      OP_VXVY: begin
        ld_a = RAD_W'(vx);
        ld_b = vy;
      end
      default: begin
        ld_a   = '0;
        ld_b   = '0;
        ld_neg = 1'b0;
      end
    endcase
  end

  assign prod_v = acc[V_W-1:0];
  assign sp     = prod_neg ? -signed'({2'b00, prod_v}) : signed'({2'b00, prod_v});

  // restoring square root, two radicand bits a step
  assign sq_cur   = {srem, acc[RAD_W-1 -: 2]};
  assign sq_trial = {1'b0, root, 2'b01};
  assign sq_ge    = (sq_cur >= sq_trial);

  assign neg = num[NUM_W-1];
  assign mag = neg ? unsigned'(-num) : unsigned'(num);

  assign div_r2    = {srem[V_W-1:0], 1'b0};
  assign div_ge    = (div_r2 >= {1'b0, root});
  assign frac_next = {frac[FRAC_BITS-2:0], div_ge};
  assign corr_next = neg ? -signed'({1'b0, frac_next}) : signed'({1'b0, frac_next});

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_ACC;
      op           <= OP_NSXX;
      pair_count   <= '0;
      sum_x        <= '0;
      sum_y        <= '0;
      sum_xx       <= '0;
      sum_yy       <= '0;
      sum_xy       <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != ST_OUT) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_ACC: begin
          if (accept) begin
            if (pair_count < CNT_W'(MAX_SAMPLES)) begin
              sum_x      <= sum_x + {{(SUM_W-SAMPLE_BITS){xs[SAMPLE_BITS-1]}}, xs};
              sum_y      <= sum_y + {{(SUM_W-SAMPLE_BITS){ys[SAMPLE_BITS-1]}}, ys};
              sum_xx     <= sum_xx + {{(SQ_W-2*SAMPLE_BITS){1'b0}}, pxx};
              sum_yy     <= sum_yy + {{(SQ_W-2*SAMPLE_BITS){1'b0}}, pyy};
              sum_xy     <= sum_xy + {{(XY_W-2*SAMPLE_BITS){pxy[2*SAMPLE_BITS-1]}}, pxy};
              pair_count <= pair_count + 1'b1;
            end
            if (sample.last) begin
              op    <= OP_NSXX;
              state <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          acc      <= '0;
          mcand    <= ld_a;
          mplier   <= ld_b;
          prod_neg <= ld_neg;
          state    <= ST_MUL;
        end
        ST_MUL: begin
          if (mplier == '0) begin
            state <= ST_STORE;
          end else begin
            if (mplier[0]) begin
              acc <= acc + mcand;
            end
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
          end
        end
        ST_STORE: begin
          case (op)
            OP_NSXX: vx  <= prod_v;
            OP_SXSX: vx  <= vx - prod_v;
            OP_NSYY: vy  <= prod_v;
            OP_SYSY: vy  <= vy - prod_v;
            OP_NSXY: num <= sp;
            OP_SXSY: num <= num - sp;
            default: ;
          endcase
          if (op == OP_VXVY) begin
            root  <= '0;
            srem  <= '0;
            step  <= '0;
            state <= ST_SQRT;
          end else begin
            op    <= op + 1'b1;
            state <= ST_LOAD;
          end
        end
        ST_SQRT: begin
          srem <= sq_ge ? (sq_cur[V_W:0] - sq_trial[V_W:0]) : sq_cur[V_W:0];
          root <= {root[V_W-2:0], sq_ge};
          acc  <= acc << 2;
          step <= step + 1'b1;
          if (step == STEP_W'(V_W - 1)) begin
            state <= ST_DIV_INIT;
          end
        end
        ST_DIV_INIT: begin
          if (root == '0) begin
            res_hold.correlation <= '0;
            res_hold.degenerate  <= 1'b1;
            state                <= ST_OUT;
          end else if (mag >= {2'b00, root}) begin
            res_hold.correlation <= neg ? CORR_MIN : CORR_MAX;
            res_hold.degenerate  <= 1'b0;
            state                <= ST_OUT;
          end else begin
            srem  <= mag[V_W:0];
            frac  <= '0;
            step  <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          srem <= div_ge ? (div_r2 - {1'b0, root}) : div_r2;
          frac <= frac_next;
          step <= step + 1'b1;
          if (step == STEP_W'(FRAC_BITS - 1)) begin
            res_hold.correlation <= corr_next;
            res_hold.degenerate  <= 1'b0;
            state                <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            result       <= res_hold;
            pair_count   <= '0;
            sum_x        <= '0;
            sum_y        <= '0;
            sum_xx       <= '0;
            sum_yy       <= '0;
            sum_xy       <= '0;
            state        <= ST_ACC;
          end
        end
        default: state <= ST_ACC;
      endcase
    end
  end

endmodule

// ===== design/pc_checker.sv =====
// Port-level checks for the Pearson correlation block, bound to the top level.
module pc_checker (
  input logic             clk,
  input logic             rst,
  input logic             sample_valid,
  input logic             sample_stall,
  input pc_pkg::sample_t  sample,
  input logic             result_valid,
  input logic             result_stall,
  input pc_pkg::result_t  result
);
  import pc_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result request changed");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |-> result.correlation == '0)
    else $error("degenerate result with non-zero correlation");

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall && sample.last |=> sample_stall)
    else $error("input not stalled after last pair");

  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_stall))
    else $error("result request without preceding computation");

endmodule

bind pearson_correlation pc_checker u_pc_checker (.*);
